@@ rtl/md5sh_pkg.sv @@
// Shared types, constants and round functions of the MD5 stream hasher.
package md5sh_pkg;

  localparam int unsigned CNT_W = 61;

  localparam logic [31:0] IV [4] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476};

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [3:0] LEN_LO_IDX = 4'd14;
  localparam logic [3:0] LEN_HI_IDX = 4'd15;

  localparam logic [31:0] RND_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CPREP,
    ST_ROUND,
    ST_CFIN,
    ST_PAD,
    ST_ZERO,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_OUT
  } md5sh_state_t;

  typedef struct packed {
    logic byte_wr;
    logic pad_wr;
    logic zero_wr;
    logic len_lo_wr;
    logic len_hi_wr;
    logic c_load;
    logic c_round;
    logic c_fin;
    logic out_pop;
  } md5sh_cmd_t;

  typedef struct packed {
    logic cnt_end;
    logic long_pad;
    logic wp_zero;
    logic wp_len;
    logic rnd_last;
    logic oidx_last;
  } md5sh_sts_t;

  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
      default: g = 4'(i[3:0] * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] mix_f(input logic [1:0] ph, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (ph)
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = c ^ (d & (b ^ c));
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] xx;
    xx = {x, x} << s;
    return xx[63:32];
  endfunction

endpackage

@@ rtl/md5sh_ctrl.sv @@
// Controller state machine of the MD5 stream hasher: fill, padding, compression, output.
module md5sh_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_present,
  input  logic                   in_end,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  md5sh_pkg::md5sh_sts_t  sts,
  output md5sh_pkg::md5sh_cmd_t  cmd
);

  md5sh_pkg::md5sh_state_t state_r, state_nxt;
  md5sh_pkg::md5sh_state_t ret_r, ret_nxt;
  logic                    long_pend_r, long_pend_nxt;
  logic                    zero_cmp;
  logic                    zero_done;

  assign zero_cmp  = long_pend_r && sts.wp_zero;
  assign zero_done = !long_pend_r && sts.wp_len;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    long_pend_nxt = long_pend_r;
    unique case (state_r)
      md5sh_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_present && sts.cnt_end) begin
            state_nxt = md5sh_pkg::ST_CPREP;
            ret_nxt   = in_end ? md5sh_pkg::ST_PAD : md5sh_pkg::ST_IDLE;
          end else if (in_end) begin
            state_nxt = md5sh_pkg::ST_PAD;
          end
        end
      end
      md5sh_pkg::ST_CPREP: state_nxt = md5sh_pkg::ST_ROUND;
      md5sh_pkg::ST_ROUND: begin
        if (sts.rnd_last) begin
          state_nxt = md5sh_pkg::ST_CFIN;
        end
      end
      md5sh_pkg::ST_CFIN: state_nxt = ret_r;
      md5sh_pkg::ST_PAD: begin
        state_nxt     = md5sh_pkg::ST_ZERO;
        long_pend_nxt = sts.long_pad;
      end
      md5sh_pkg::ST_ZERO: begin
        if (zero_cmp) begin
          state_nxt     = md5sh_pkg::ST_CPREP;
          ret_nxt       = md5sh_pkg::ST_ZERO;
          long_pend_nxt = 1'b0;
        end else if (zero_done) begin
          state_nxt = md5sh_pkg::ST_LEN_LO;
        end
      end
      md5sh_pkg::ST_LEN_LO: state_nxt = md5sh_pkg::ST_LEN_HI;
      md5sh_pkg::ST_LEN_HI: begin
        state_nxt = md5sh_pkg::ST_CPREP;
        ret_nxt   = md5sh_pkg::ST_OUT;
      end
      md5sh_pkg::ST_OUT: begin
        if (out_tready && sts.oidx_last) begin
          state_nxt = md5sh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = md5sh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    unique case (state_r)
      md5sh_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.byte_wr = in_tvalid && in_present;
      end
      md5sh_pkg::ST_CPREP:  cmd.c_load    = 1'b1;
      md5sh_pkg::ST_ROUND:  cmd.c_round   = 1'b1;
      md5sh_pkg::ST_CFIN:   cmd.c_fin     = 1'b1;
      md5sh_pkg::ST_PAD:    cmd.pad_wr    = 1'b1;
      md5sh_pkg::ST_ZERO:   cmd.zero_wr   = !zero_cmp && !zero_done;
      md5sh_pkg::ST_LEN_LO: cmd.len_lo_wr = 1'b1;
      md5sh_pkg::ST_LEN_HI: cmd.len_hi_wr = 1'b1;
      md5sh_pkg::ST_OUT: begin
        out_tvalid  = 1'b1;
        cmd.out_pop = out_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= md5sh_pkg::ST_IDLE;
      ret_r       <= md5sh_pkg::ST_IDLE;
      long_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      long_pend_r <= long_pend_nxt;
    end
  end

endmodule

@@ rtl/md5sh_dpath.sv @@
// Datapath of the MD5 stream hasher: block memory, byte count, round unit and chaining words.
module md5sh_dpath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_byte,
  input  md5sh_pkg::md5sh_cmd_t  cmd,
  output md5sh_pkg::md5sh_sts_t  sts,
  output logic [31:0]            out_word,
  output logic [1:0]             out_idx
);

  logic [31:0] mem [16];
  logic [31:0] rdata_r;
  logic [3:0]  raddr;
  logic        we;
  logic [3:0]  waddr;
  logic [31:0] wdata;

  logic [md5sh_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  wp_r, wp_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [1:0]  oidx_r, oidx_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];

  logic [31:0] acc_set;
  logic [31:0] pad_word;
  logic [63:0] bit_len;
  logic [31:0] t_sum;
  logic [31:0] rot;

  assign bit_len = {cnt_r, 3'b000};

  always_comb begin
    acc_set = acc_r;
    acc_set[{cnt_r[1:0], 3'b000} +: 8] = in_byte;
  end

  always_comb begin
    pad_word = '0;
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < cnt_r[1:0]) begin
        pad_word[8*j +: 8] = acc_r[8*j +: 8];
      end else if (2'(j) == cnt_r[1:0]) begin
        pad_word[8*j +: 8] = md5sh_pkg::PAD_BYTE;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[5:2];
    wdata = acc_set;
    if (cmd.byte_wr) begin
      we = (cnt_r[1:0] == 2'd3);
    end else if (cmd.pad_wr) begin
      we    = 1'b1;
      wdata = pad_word;
    end else if (cmd.zero_wr) begin
      we    = 1'b1;
      waddr = wp_r;
      wdata = '0;
    end else if (cmd.len_lo_wr) begin
      we    = 1'b1;
      waddr = md5sh_pkg::LEN_LO_IDX;
      wdata = bit_len[31:0];
    end else if (cmd.len_hi_wr) begin
      we    = 1'b1;
      waddr = md5sh_pkg::LEN_HI_IDX;
      wdata = bit_len[63:32];
    end
  end

  assign raddr = cmd.c_load ? 4'd0 : md5sh_pkg::msg_idx(6'(rnd_r + 6'd1));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign t_sum = a_r + md5sh_pkg::mix_f(rnd_r[5:4], b_r, c_r, d_r) + rdata_r
                 + md5sh_pkg::RND_K[rnd_r];
  assign rot   = md5sh_pkg::rotl(t_sum, md5sh_pkg::ROT_S[{rnd_r[5:4], rnd_r[1:0]}]);

  always_comb begin
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    wp_nxt    = wp_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    chain_nxt = chain_r;
    if (cmd.byte_wr) begin
      acc_nxt = acc_set;
      cnt_nxt = cnt_r + {{(md5sh_pkg::CNT_W-1){1'b0}}, 1'b1};
    end
    if (cmd.pad_wr) begin
      wp_nxt = cnt_r[5:2] + 4'd1;
    end
    if (cmd.zero_wr) begin
      wp_nxt = wp_r + 4'd1;
    end
    if (cmd.c_load) begin
      rnd_nxt = '0;
      a_nxt   = chain_r[0];
      b_nxt   = chain_r[1];
      c_nxt   = chain_r[2];
      d_nxt   = chain_r[3];
    end
    if (cmd.c_round) begin
      rnd_nxt = rnd_r + 6'd1;
      a_nxt   = d_r;
      d_nxt   = c_r;
      c_nxt   = b_r;
      b_nxt   = b_r + rot;
    end
    if (cmd.c_fin) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
    end
    if (cmd.out_pop) begin
      oidx_nxt = oidx_r + 2'd1;
      if (oidx_r == 2'd3) begin
        chain_nxt = md5sh_pkg::IV;
        cnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      wp_r    <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      chain_r <= md5sh_pkg::IV;
    end else begin
      cnt_r   <= cnt_nxt;
      wp_r    <= wp_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
  end

  assign sts.cnt_end   = (cnt_r[5:0] == 6'h3F);
  assign sts.long_pad  = (cnt_r[5:3] == 3'b111);
  assign sts.wp_zero   = (wp_r == 4'd0);
  assign sts.wp_len    = (wp_r == md5sh_pkg::LEN_LO_IDX);
  assign sts.rnd_last  = (rnd_r == 6'h3F);
  assign sts.oidx_last = (oidx_r == 2'd3);

  assign out_word = chain_r[oidx_r];
  assign out_idx  = oidx_r;

endmodule

@@ rtl/md5_stream_hasher_unit.sv @@
// MD5 stream hasher: top level joining controller and datapath.
// Input beats carry one message byte in in_tdata, in_tuser high when the byte is part of
// the message, and in_tlast to close the message after that byte. A beat with in_tuser
// and in_tlast both low is taken and ignored.
// The beat that completes a 64-byte block holds in_tready low during the compression
// (load, 64 rounds through one shared round unit, chain update), so no byte is taken
// until that block is compressed.
// After the closing beat the block writes the padding word, zero words up to word 13,
// the two length words, and compresses. When fewer than 9 bytes of the last block are
// free, it adds one more compression and the clearing of words 0 to 13.
// The digest then leaves as four out beats, word 0 first, out_tuser the word index and
// out_tlast on word 3. While out_tready is low the current word holds and no input is
// taken. After the fourth beat the chaining words and byte count return to their initial
// values and in_tready rises. Reset (rst_n low, synchronous) gives the same state.
module md5_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] byte_present
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast
);

  md5sh_pkg::md5sh_cmd_t cmd;
  md5sh_pkg::md5sh_sts_t sts;

  md5sh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_present (in_tuser[0]),
    .in_end     (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  md5sh_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_tdata),
    .out_idx  (out_tuser)
  );

  assign out_tlast = sts.oidx_last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while digest pending");

  a_words_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("digest words not contiguous");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && out_tuser == 2'd0))
    else $error("no return to idle after last digest word");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for md5_stream_hasher_unit: byte messages checked against an in-bench MD5.
module tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam logic [7:0]  PAD_MARK    = 8'h80;

  localparam logic [31:0] MD5_INIT [4] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476};

  localparam logic [31:0] MD5_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam int unsigned MD5_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  localparam int unsigned BOUND_LENS [12] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128, 0};

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       fin;
    logic       drain;
  } byte_beat_t;

  typedef struct {
    logic [31:0] dig_word;
    logic [1:0]  dig_idx;
    logic        dig_last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [0:0]  in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  byte_beat_t   beat_q [$];
  digest_beat_t digest_q [$];

  logic [31:0] md5_chain [4];
  logic [7:0]  msg_buf [64];
  logic [60:0] msg_len;

  int unsigned n_items = 0;
  int unsigned n_err = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rdy_left = 0;
  logic        nxt_valid;
  logic        nxt_ready;
  byte_beat_t  cur_beat;
  digest_beat_t exp_beat;

  md5_stream_hasher_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void md5_restart();
    for (int k = 0; k < 4; k++) md5_chain[k] = MD5_INIT[k];
    msg_len = '0;
  endfunction

  function automatic void md5_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned g;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_buf[4*i+3], msg_buf[4*i+2], msg_buf[4*i+1], msg_buf[4*i]};
    a = md5_chain[0];
    b = md5_chain[1];
    c = md5_chain[2];
    d = md5_chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = a + f + w[g] + MD5_K[i];
      a = d;
      d = c;
      c = b;
      b = b + rol32(t, MD5_S[(i / 16) * 4 + (i % 4)]);
    end
    md5_chain[0] = md5_chain[0] + a;
    md5_chain[1] = md5_chain[1] + b;
    md5_chain[2] = md5_chain[2] + c;
    md5_chain[3] = md5_chain[3] + d;
  endfunction

  // Absorb one accepted beat; on the closing beat pad, compress and queue the digest words.
  function automatic void md5_absorb(input logic [7:0] db, input logic pres, input logic fin);
    logic [63:0]  bit_len;
    int unsigned  pos;
    digest_beat_t dw;
    if (pres) begin
      msg_buf[msg_len[5:0]] = db;
      msg_len = msg_len + 61'd1;
      if (msg_len[5:0] == 6'd0) md5_compress();
    end
    if (fin) begin
      bit_len = {msg_len, 3'b000};
      pos = msg_len[5:0];
      msg_buf[pos] = PAD_MARK;
      for (int i = pos + 1; i < 64; i++) msg_buf[i] = 8'h00;
      if (pos >= 56) begin
        md5_compress();
        for (int i = 0; i < 56; i++) msg_buf[i] = 8'h00;
      end
      for (int k = 0; k < 8; k++) msg_buf[56 + k] = bit_len[8*k +: 8];
      md5_compress();
      for (int k = 0; k < 4; k++) begin
        dw.dig_word = md5_chain[k];
        dw.dig_idx  = 2'(k);
        dw.dig_last = (k == 3);
        digest_q.push_back(dw);
      end
      md5_restart();
    end
  endfunction

  function automatic void queue_beat(input logic [7:0] db, input logic pres, input logic fin,
                                     input logic drain);
    byte_beat_t bb;
    bb.data    = db;
    bb.present = pres;
    bb.fin     = fin;
    bb.drain   = drain;
    beat_q.push_back(bb);
    if (pres || fin) n_items++;
  endfunction

  task automatic queue_message(input int unsigned len, input bit split_fin, input bit drain);
    logic [7:0]  db;
    int unsigned fill;
    fill = $urandom_range(0, 5);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      db = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      queue_beat(db, 1'b1, !split_fin && (i == len - 1), drain && (i == 0));
    end
    if (split_fin || len == 0)
      queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && (len == 0));
  endtask

  // Driver: bursts of beats with random gaps; a drain beat holds until all digests are back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      md5_restart();
    end else begin
      if (in_tvalid && in_tready) md5_absorb(in_tdata, in_tuser[0], in_tlast);
      if (!in_tvalid || in_tready) begin
        nxt_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (beat_q.size() != 0 && !(beat_q[0].drain && digest_q.size() != 0)) begin
          cur_beat = beat_q.pop_front();
          in_tdata <= cur_beat.data;
          in_tuser <= cur_beat.present;
          in_tlast <= cur_beat.fin;
          nxt_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
        in_tvalid <= nxt_valid;
      end
    end
  end

  // Receiver: ready and stall stretches of random length.
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      nxt_ready = ($urandom_range(0, 2) != 0);
      rdy_left = nxt_ready ? $urandom_range(1, 30) : $urandom_range(1, 10);
      out_tready <= nxt_ready;
    end else begin
      rdy_left--;
    end
  end

  // Monitor: compare each digest beat with the oldest expected word.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        $error("digest beat with nothing expected: digest_word %h", out_tdata);
        n_err++;
      end else begin
        exp_beat = digest_q.pop_front();
        if (out_tdata !== exp_beat.dig_word) begin
          $error("digest_word mismatch: expected %h, got %h", exp_beat.dig_word, out_tdata);
          n_err++;
        end
        if (out_tuser !== exp_beat.dig_idx) begin
          $error("word_index mismatch: expected %0d, got %0d", exp_beat.dig_idx, out_tuser);
          n_err++;
        end
        if (out_tlast !== exp_beat.dig_last) begin
          $error("last_word mismatch: expected %0d, got %0d", exp_beat.dig_last, out_tlast);
          n_err++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned sel;
    int unsigned n_msgs;
    n_msgs = 0;

    // empty message, idle beats, short messages with inline and separate close
    queue_beat(8'h00, 1'b0, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_beat(8'h5A, 1'b0, 1'b0, 1'b0);
    queue_beat(8'h61, 1'b1, 1'b0, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b0, 1'b0);
    queue_beat(8'h63, 1'b1, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b1, 1'b0, 1'b0);
    queue_beat(8'hFF, 1'b0, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b1, 1'b0, 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b0, 1'b0);
    queue_beat(8'h80, 1'b1, 1'b0, 1'b0);
    queue_beat(8'h7F, 1'b1, 1'b0, 1'b0);
    queue_beat(8'hA5, 1'b0, 1'b0, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b0, 1'b1, 1'b0);
    queue_beat(8'h55, 1'b1, 1'b1, 1'b0);

    // random messages, weighted towards padding boundaries
    while (n_items < 300) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)      len = $urandom_range(0, 12);
      else if (sel < 7) len = BOUND_LENS[$urandom_range(0, 11)];
      else              len = $urandom_range(0, 140);
      queue_message(len, $urandom_range(0, 2) == 0, n_msgs == 0 || $urandom_range(0, 7) == 0);
      n_msgs++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (beat_q.size() != 0 || in_tvalid || digest_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
